[sv/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on clk, quiet while rst is high
`define GBCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check sampled on clk, also active during reset
`define GBCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/gbce_pkg.sv]
// ----------------------------------------------------------------------------
// gbce_pkg
// Shared constants, codes and types of the graph search and component engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gbce_pkg;

  localparam int NumVert   = 32;
  localparam int MaxDegree = 32;
  localparam int VidW      = $clog2(NumVert);
  localparam int DegW      = $clog2(MaxDegree) + 1;
  localparam int CntW      = $clog2(NumVert) + 1;
  localparam int NbrAddrW  = $clog2(NumVert * MaxDegree);

  // input operations
  localparam logic [1:0] ModeAddVertex = 2'd0;
  localparam logic [1:0] ModeAddEdge   = 2'd1;
  localparam logic [1:0] ModeSearch    = 2'd2;
  localparam logic [1:0] ModeCount     = 2'd3;

  // result codes
  localparam logic [2:0] StDone    = 3'd0;
  localparam logic [2:0] StVisit   = 3'd1;
  localparam logic [2:0] StCount   = 3'd2;
  localparam logic [2:0] StAbsent  = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;
  localparam logic [2:0] StIgnored = 3'd5;

  // write port of the adjacency memory
  typedef struct packed {
    logic                en;
    logic [NbrAddrW-1:0] addr;
    logic [VidW-1:0]     data;
  } nbr_wr_t;

endpackage

`default_nettype wire

[sv/graph_bfs_and_component_engine_top.sv]
// ----------------------------------------------------------------------------
// graph_bfs_and_component_engine_top
// Undirected graph store with breadth-first search and component count.
//
//   channel  signals                                          direction
//   in       in_valid in_stall mode vertex_a vertex_b         to block
//   out      out_valid out_stall status vertex_id hop_distance
//            group_count last                                 from block
//
// Add vertex finishes in S_DECODE; add edge reads both degrees, then is
// refused in S_EDGE_CK or stored in S_EDGE_CK and S_EDGE_W2, plus output waits.
// A search or count reads each adjacency entry in S_SCAN and S_NB, dequeues
// each vertex in S_POP, S_LOAD and S_SCAN and finds the queue empty in S_POP;
// the count also scans each vertex id in S_CSCAN.
// Adjacency reads go through one registered memory port, which sets the rate.
// rst clears present, degree and visited flops; adjacency memory is not cleared.
// out_stall holds the output register; the walk waits whenever a result
// cannot be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_bfs_and_component_engine_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                mode,
  input  wire logic [gbce_pkg::VidW-1:0] vertex_a,
  input  wire logic [gbce_pkg::VidW-1:0] vertex_b,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     status,
  output logic [gbce_pkg::VidW-1:0]      vertex_id,
  output logic [gbce_pkg::VidW-1:0]      hop_distance,
  output logic [gbce_pkg::CntW-1:0]      group_count,
  output logic                           last
);
  import gbce_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_EDGE_DA = 4'd2;
  localparam logic [3:0] S_EDGE_DB = 4'd3;
  localparam logic [3:0] S_EDGE_CK = 4'd4;
  localparam logic [3:0] S_EDGE_W2 = 4'd5;
  localparam logic [3:0] S_POP     = 4'd6;
  localparam logic [3:0] S_LOAD    = 4'd7;
  localparam logic [3:0] S_SCAN    = 4'd8;
  localparam logic [3:0] S_NB      = 4'd9;
  localparam logic [3:0] S_FLUSH   = 4'd10;
  localparam logic [3:0] S_CSCAN   = 4'd11;
  localparam logic [3:0] S_CEMIT   = 4'd12;

  localparam int QW = 2 * VidW;

  logic [3:0]          state;
  logic [1:0]          op;
  logic [VidW-1:0]     va;
  logic [VidW-1:0]     vb;
  logic [NumVert-1:0]  present;
  logic [NumVert-1:0]  visited;
  logic [DegW-1:0]     degree [NumVert];
  logic [DegW-1:0]     deg_a;
  logic [DegW-1:0]     deg_b;
  logic [DegW-1:0]     deg_cur;
  logic [DegW-1:0]     idx;
  logic [VidW-1:0]     cur;
  logic [VidW-1:0]     cur_hop;
  logic [CntW-1:0]     head;
  logic [CntW-1:0]     tail;
  logic [CntW-1:0]     cv;
  logic [CntW-1:0]     groups;
  logic                report;
  logic [QW-1:0]       queue_mem [NumVert];
  logic [QW-1:0]       q_rd;
  logic [VidW-1:0]     hold_vid;
  logic [VidW-1:0]     hold_hop;

  logic [VidW-1:0]     deg_addr;
  logic [DegW-1:0]     deg_rd;
  logic                can_load;
  logic                out_load;
  logic                q_we;
  logic [QW-1:0]       q_wdata;
  logic [VidW-1:0]     nb_rd;
  logic [NbrAddrW-1:0] nb_raddr;
  nbr_wr_t             nb_wr;

  assign in_stall = (state != S_IDLE);
  assign can_load = !out_valid || !out_stall;

  // degree lookup at one address per cycle
  always_comb begin
    unique case (state)
      S_EDGE_DA: deg_addr = va;
      S_EDGE_DB: deg_addr = vb;
      default:   deg_addr = q_rd[VidW-1:0];
    endcase
  end
  assign deg_rd = degree[deg_addr];

  // adjacency memory
  always_comb begin
    nb_wr.en   = 1'b0;
    nb_wr.addr = {va, deg_a[VidW-1:0]};
    nb_wr.data = vb;
    if (state == S_EDGE_CK && present[va] && present[vb] && va != vb &&
        deg_a != DegW'(MaxDegree) && deg_b != DegW'(MaxDegree)) begin
      nb_wr.en = 1'b1;
    end else if (state == S_EDGE_W2 && can_load) begin
      nb_wr.en   = 1'b1;
      nb_wr.addr = {vb, deg_b[VidW-1:0]};
      nb_wr.data = va;
    end
  end
  assign nb_raddr = {cur, idx[VidW-1:0]};

  gbce_nbr_ram u_nbr_ram (
    .clk     (clk),
    .wr      (nb_wr),
    .rd_addr (nb_raddr),
    .rd_data (nb_rd)
  );

  // a result enters the output register this cycle
  always_comb begin
    out_load = 1'b0;
    if (can_load) begin
      unique case (state)
        S_DECODE:  out_load = (op == ModeAddVertex) || (op == ModeSearch && !present[va]);
        S_EDGE_CK: out_load = !nb_wr.en;
        S_EDGE_W2: out_load = 1'b1;
        S_NB:      out_load = report && !visited[nb_rd];
        S_FLUSH:   out_load = 1'b1;
        S_CEMIT:   out_load = 1'b1;
        default:   out_load = 1'b0;
      endcase
    end
  end

  // queue write for a newly reached neighbor
  assign q_we    = (state == S_NB) && !visited[nb_rd] && (!report || can_load) &&
                   (tail != CntW'(NumVert));
  assign q_wdata = {cur_hop + VidW'(1), nb_rd};

  // work queue memory: entry is {hop, vertex}
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[tail[VidW-1:0]] <= q_wdata;
    end else if (state == S_DECODE && op == ModeSearch) begin
      queue_mem[0] <= {VidW'(0), va};
    end else if (state == S_CSCAN && cv != CntW'(NumVert) &&
                 present[cv[VidW-1:0]] && !visited[cv[VidW-1:0]]) begin
      queue_mem[0] <= {VidW'(0), cv[VidW-1:0]};
    end
    if (state == S_POP) begin
      q_rd <= queue_mem[head[VidW-1:0]];
    end
  end

  // control sequencer and graph state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      present    <= '0;
      visited    <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NumVert; i++) begin
        degree[i] <= '0;
      end
    end else begin
      // output register: load a new result or release a transferred one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= mode;
            va    <= vertex_a;
            vb    <= vertex_b;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (op)
            ModeAddVertex: begin
              if (can_load) begin
                status       <= present[va] ? StIgnored : StDone;
                vertex_id    <= '0;
                hop_distance <= '0;
                group_count  <= '0;
                last         <= 1'b1;
                if (!present[va]) begin
                  present[va] <= 1'b1;
                  degree[va]  <= '0;
                end
                state <= S_IDLE;
              end
            end
            ModeAddEdge: state <= S_EDGE_DA;
            ModeSearch: begin
              if (!present[va]) begin
                if (can_load) begin
                  status       <= StAbsent;
                  vertex_id    <= '0;
                  hop_distance <= '0;
                  group_count  <= '0;
                  last         <= 1'b1;
                  state        <= S_IDLE;
                end
              end else begin
                visited     <= NumVert'(1) << va;
                head        <= '0;
                tail        <= CntW'(1);
                report      <= 1'b1;
                hold_vid    <= va;
                hold_hop    <= '0;
                state       <= S_POP;
              end
            end
            ModeCount: begin
              visited <= '0;
              cv      <= '0;
              groups  <= '0;
              report  <= 1'b0;
              state   <= S_CSCAN;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_EDGE_DA: begin
          deg_a <= deg_rd;
          state <= S_EDGE_DB;
        end
        S_EDGE_DB: begin
          deg_b <= deg_rd;
          state <= S_EDGE_CK;
        end
        S_EDGE_CK: begin
          if (nb_wr.en) begin
            degree[va] <= deg_a + DegW'(1);
            state      <= S_EDGE_W2;
          end else if (can_load) begin
            vertex_id    <= '0;
            hop_distance <= '0;
            group_count  <= '0;
            last         <= 1'b1;
            priority if (!present[va] || !present[vb]) begin
              status <= StAbsent;
            end else if (va == vb) begin
              status <= StIgnored;
            end else begin
              status <= StFull;
            end
            state <= S_IDLE;
          end
        end
        S_EDGE_W2: begin
          if (can_load) begin
            degree[vb]   <= deg_b + DegW'(1);
            status       <= StDone;
            vertex_id    <= '0;
            hop_distance <= '0;
            group_count  <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        // take the next vertex off the queue
        S_POP: begin
          if (head == tail) begin
            state <= report ? S_FLUSH : S_CSCAN;
          end else begin
            head  <= head + CntW'(1);
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cur     <= q_rd[VidW-1:0];
          cur_hop <= q_rd[QW-1:VidW];
          deg_cur <= deg_rd;
          idx     <= '0;
          state   <= S_SCAN;
        end
        // issue the next adjacency read
        S_SCAN: begin
          if (idx == deg_cur) begin
            state <= S_POP;
          end else begin
            state <= S_NB;
          end
        end
        S_NB: begin
          if (visited[nb_rd]) begin
            idx   <= idx + DegW'(1);
            state <= S_SCAN;
          end else if (!report || can_load) begin
            visited[nb_rd] <= 1'b1;
            if (q_we) begin
              tail <= tail + CntW'(1);
            end
            if (report) begin
              // send the held visit, keep the new one for the last flag
              status       <= StVisit;
              vertex_id    <= hold_vid;
              hop_distance <= hold_hop;
              group_count  <= '0;
              last         <= 1'b0;
              hold_vid     <= nb_rd;
              hold_hop     <= cur_hop + VidW'(1);
            end
            idx   <= idx + DegW'(1);
            state <= S_SCAN;
          end
        end
        S_FLUSH: begin
          if (can_load) begin
            status       <= StVisit;
            vertex_id    <= hold_vid;
            hop_distance <= hold_hop;
            group_count  <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        // scan vertex ids for unvisited present roots
        S_CSCAN: begin
          if (cv == CntW'(NumVert)) begin
            state <= S_CEMIT;
          end else begin
            cv <= cv + CntW'(1);
            if (present[cv[VidW-1:0]] && !visited[cv[VidW-1:0]]) begin
              visited[cv[VidW-1:0]] <= 1'b1;
              groups <= groups + CntW'(1);
              head   <= '0;
              tail   <= CntW'(1);
              state  <= S_POP;
            end
          end
        end
        S_CEMIT: begin
          if (can_load) begin
            status       <= StCount;
            vertex_id    <= '0;
            hop_distance <= '0;
            group_count  <= groups;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/gbce_nbr_ram.sv]
// ----------------------------------------------------------------------------
// gbce_nbr_ram
// Adjacency list memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbce_nbr_ram (
  input  wire logic                          clk,
  input  wire gbce_pkg::nbr_wr_t             wr,
  input  wire logic [gbce_pkg::NbrAddrW-1:0] rd_addr,
  output logic      [gbce_pkg::VidW-1:0]     rd_data
);
  import gbce_pkg::*;

  logic [VidW-1:0] mem [NumVert*MaxDegree];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[sv/gbce_checker.sv]
// ----------------------------------------------------------------------------
// gbce_checker
// Port level checks of the graph engine, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gbce_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [2:0]                status,
  input wire logic [gbce_pkg::CntW-1:0] group_count,
  input wire logic                      last
);
  import gbce_pkg::*;

  // a stalled result stays offered
  `GBCE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped")
  // only defined result codes leave the block
  `GBCE_ASSERT(a_status_ok, out_valid |-> status <= StIgnored, "bad status")
  // every result other than a visit ends its item
  `GBCE_ASSERT(a_single_last, out_valid && status != StVisit |-> last, "missing last")
  // count field is zero outside count results
  `GBCE_ASSERT(a_count_zero, out_valid && status != StCount |-> group_count == '0, "stray count")
  // no result in the cycle after reset
  `GBCE_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "output after reset")

endmodule

bind graph_bfs_and_component_engine_top gbce_checker u_gbce_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .group_count (group_count),
  .last        (last)
);

`default_nettype wire
